// ----- hdl/dsb_pkg.sv -----
// ----------------------------------------------------------------------------
// dsb_pkg
// Shared constants, the core control struct and the twiddle table for the
// selected-bin transform.
// ----------------------------------------------------------------------------
package dsb_pkg;

  localparam int MaxPoints = 4096;
  localparam int AddrW     = $clog2(MaxPoints);
  localparam int CntW      = AddrW + 1;
  localparam int TableSize = 1024;
  localparam int TabW      = $clog2(TableSize);
  localparam int MaxHarm   = 31;
  localparam int DivW      = 31;
  localparam int AccW      = 42;
  localparam int CoordW    = 12;
  localparam int CoefW     = 17;

  localparam longint OneQ30    = 64'sd1 << 30;
  localparam longint HalfPiQ30 = 64'sd1686629713;

  // control word from the sequencer to the accumulate core
  typedef struct packed {
    logic              start;
    logic [CntW-1:0]   n_pts;
    logic [CntW-1:0]   nmod;
    logic [TabW-1:0]   step_q;
    logic [CntW:0]     step_r;
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
  } core_ctrl_t;

  typedef logic [31:0] twid_arr_t [TableSize];

  // taylor series by horner, each stage clamped to [0, 1] in q30
  function automatic longint horner(longint x2, bit is_sin);
    longint t;
    longint p;
    t = OneQ30;
    for (int i = 0; i < 6; i++) begin
      p = (x2 * t) >>> 30;
      case (i)
        0:       p = is_sin ? p / 156 : p / 132;
        1:       p = is_sin ? p / 110 : p / 90;
        2:       p = is_sin ? p / 72  : p / 56;
        3:       p = is_sin ? p / 42  : p / 30;
        4:       p = is_sin ? p / 20  : p / 12;
        default: p = is_sin ? p / 6   : p / 2;
      endcase
      t = OneQ30 - p;
      if (t < 0) t = 0;
      if (t > OneQ30) t = OneQ30;
    end
    return t;
  endfunction

  function automatic longint to_q15(longint v);
    longint w;
    longint r;
    w = v;
    if (w < 0) w = 0;
    if (w > OneQ30) w = OneQ30;
    r = (w + (64'sd1 << 14)) >>> 15;
    return (r > 32767) ? 64'sd32767 : r;
  endfunction

  // {cos, sin} in q1.15 for each table index
  function automatic twid_arr_t build_twid();
    twid_arr_t tab;
    longint    x;
    longint    x2;
    longint    s;
    longint    c15;
    longint    s15;
    longint    cv;
    longint    sv;
    int        quad;
    int        rm;
    for (int k = 0; k < TableSize; k++) begin
      quad = (k * 4) / TableSize;
      rm   = (k * 4) % TableSize;
      x    = (longint'(rm) * HalfPiQ30) / TableSize;
      x2   = (x * x) >>> 30;
      s    = (x * horner(x2, 1'b1)) >>> 30;
      c15  = to_q15(horner(x2, 1'b0));
      s15  = to_q15(s);
      case (quad % 4)
        0:       begin cv = c15;  sv = s15;  end
        1:       begin cv = -s15; sv = c15;  end
        2:       begin cv = -c15; sv = -s15; end
        default: begin cv = s15;  sv = -c15; end
      endcase
      tab[k] = {cv[15:0], sv[15:0]};
    end
    return tab;
  endfunction

  localparam twid_arr_t Twid = build_twid();

endpackage

// ----- hdl/dsb_div.sv -----
// ----------------------------------------------------------------------------
// dsb_div
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// ----------------------------------------------------------------------------
module dsb_div
  import dsb_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic [CntW-1:0] divisor_i,
  output logic            busy_o,
  output logic [DivW-1:0] quot_o,
  output logic [CntW-1:0] rem_o
);

  localparam int StepW = $clog2(DivW + 1);

  logic [StepW-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [DivW-1:0]  quot_q, quot_d;
  logic [CntW-1:0]  rem_q, rem_d;
  logic [CntW-1:0]  dvs_q, dvs_d;
  logic [CntW:0]    trial;

  // one shift and subtract step
  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    trial  = {rem_q, quot_q[DivW-1]};
    if (start_i) begin
      cnt_d  = StepW'(DivW);
      busy_d = 1'b1;
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d  = CntW'(trial - {1'b0, dvs_q});
        quot_d = {quot_q[DivW-2:0], 1'b1};
      end else begin
        rem_d  = trial[CntW-1:0];
        quot_d = {quot_q[DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == StepW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// ----- hdl/dsb_core.sv -----
// ----------------------------------------------------------------------------
// dsb_core
// Point store and the per-bin read, twiddle and accumulate pipeline.
// ----------------------------------------------------------------------------
module dsb_core
  import dsb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [AddrW-1:0]   wr_addr_i,
  input  logic [2*CoordW-1:0] wr_data_i,
  input  core_ctrl_t         ctrl_i,
  output logic               busy_o,
  output logic signed [AccW-1:0] sre_o,
  output logic signed [AccW-1:0] sim_o
);

  logic [2*CoordW-1:0] mem [MaxPoints];
  logic [2*CoordW-1:0] rd_q;

  logic [CntW-1:0] x_q;
  logic [CntW-1:0] p_q;
  logic [TabW:0]   k_q;
  logic [CntW:0]   r_q;
  logic            issue;
  logic [CntW:0]   p_sum;
  logic            wrap;
  logic [CntW+1:0] r_sum;
  logic            carry;
  logic [TabW+1:0] k_next;

  logic [TabW-1:0] k1_q;
  logic            v1_q, v2_q, v3_q;
  logic signed [CoordW:0] dx2_q, dy2_q;
  logic signed [15:0]     cv2_q, sv2_q;
  logic signed [CoordW+16:0] pxc_q, pys_q, pyc_q, pxs_q;
  logic signed [AccW-1:0] sre_q, sim_q;
  logic [31:0] tw;

  // point store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
    rd_q <= mem[x_q[AddrW-1:0]];
  end

  // running phase: table index k with remainder r against 2n
  assign issue  = x_q < ctrl_i.n_pts;
  assign p_sum  = {1'b0, p_q} + {1'b0, ctrl_i.nmod};
  assign wrap   = p_sum >= {1'b0, ctrl_i.n_pts};
  assign r_sum  = {1'b0, r_q} + {1'b0, ctrl_i.step_r};
  assign carry  = r_sum >= {1'b0, ctrl_i.n_pts, 1'b0};
  assign k_next = {1'b0, k_q} + (TabW+2)'(ctrl_i.step_q) + (TabW+2)'(carry)
                - (wrap ? (TabW+2)'(TableSize) : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q  <= '0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ctrl_i.start) x_q <= '0;
      else if (issue) x_q <= x_q + 1'b1;
      v1_q <= issue && !ctrl_i.start;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      p_q <= '0;
      k_q <= '0;
      r_q <= {1'b0, ctrl_i.n_pts};
    end else if (issue) begin
      p_q <= wrap ? CntW'(p_sum - {1'b0, ctrl_i.n_pts}) : p_sum[CntW-1:0];
      k_q <= k_next[TabW:0];
      r_q <= carry ? (CntW+1)'(r_sum - {1'b0, ctrl_i.n_pts, 1'b0}) : r_sum[CntW:0];
    end
    k1_q <= (k_q == (TabW+1)'(TableSize)) ? '0 : k_q[TabW-1:0];
  end

  assign tw = Twid[k1_q];

  // centered point and twiddle, then products, then sums
  always_ff @(posedge clk_i) begin
    dx2_q <= $signed({1'b0, rd_q[CoordW-1:0]}) - $signed({1'b0, ctrl_i.cx});
    dy2_q <= $signed({1'b0, rd_q[2*CoordW-1:CoordW]}) - $signed({1'b0, ctrl_i.cy});
    cv2_q <= $signed(tw[31:16]);
    sv2_q <= $signed(tw[15:0]);
    pxc_q <= dx2_q * cv2_q;
    pys_q <= dy2_q * sv2_q;
    pyc_q <= dy2_q * cv2_q;
    pxs_q <= dx2_q * sv2_q;
    if (ctrl_i.start) begin
      sre_q <= '0;
      sim_q <= '0;
    end else if (v3_q) begin
      sre_q <= sre_q + AccW'(pxc_q) + AccW'(pys_q);
      sim_q <= sim_q + AccW'(pyc_q) - AccW'(pxs_q);
    end
  end

  assign busy_o = issue || v1_q || v2_q || v3_q;
  assign sre_o  = sre_q;
  assign sim_o  = sim_q;

endmodule

// ----- hdl/dft_selected_bins.sv -----
// ----------------------------------------------------------------------------
// dft_selected_bins
// Stores traced points and, on the last point of a burst, emits the
// selected transform bins 0, -1, 1, ... -K, K.
// ----------------------------------------------------------------------------
// channel   direction  handshake            word
// in        sink       in_valid_i/in_stall_o  point_x, point_y, last_point
// out       source     out_valid_o/out_stall_i coef_re, coef_im, harmonic,
//                                              last, dropped
// cfg       apb slave  psel/penable/pready    num_harmonics, center_x/y
//
// points are taken one per cycle while no burst is being transformed.
// the last point stalls the input until the final bin word is taken. per bin
// the shared 31-step divider runs four operations, two ahead of the accumulate
// and two after it, and the bin word is then emitted. each bin word waits in
// the output register until taken.
// reset clears the point count and overflow flag; the store needs no clear.
module dft_selected_bins
  import dsb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CoordW-1:0] point_x_i,
  input  logic [CoordW-1:0] point_y_i,
  input  logic              last_point_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic signed [CoefW-1:0] coef_re_o,
  output logic signed [CoefW-1:0] coef_im_o,
  output logic signed [5:0] harmonic_o,
  output logic              last_o,
  output logic              dropped_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  typedef enum logic [1:0] {RegHarm = 2'd0, RegCx = 2'd1, RegCy = 2'd2} reg_e;
  typedef enum logic [2:0] {S_IDLE, S_DGO, S_DWAIT, S_AGO, S_AWAIT, S_EMIT} state_e;
  typedef enum logic [1:0] {OP_MOD, OP_PH, OP_RE, OP_IM} div_op_e;

  logic [4:0]        harm_q;
  logic [CoordW-1:0] cx_q, cy_q;
  logic              cfg_wr;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      harm_q <= 5'd2;
      cx_q   <= 12'd960;
      cy_q   <= 12'd540;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegHarm: harm_q <= pwdata[4:0];
        RegCx:   cx_q   <= pwdata[CoordW-1:0];
        RegCy:   cy_q   <= pwdata[CoordW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegHarm: prdata = {27'd0, harm_q};
      RegCx:   prdata = {20'd0, cx_q};
      RegCy:   prdata = {20'd0, cy_q};
      default: prdata = '0;
    endcase
  end

  state_e            state_q;
  div_op_e           op_q;
  logic [CntW-1:0]   count_q;
  logic              ovf_q;
  logic [5:0]        bin_q;
  logic [CntW-1:0]   nmod_q;
  logic [TabW-1:0]   step_q_q;
  logic [CntW:0]     step_r_q;
  logic              out_valid_q;
  logic [CoefW-1:0]  coef_re_q, coef_im_q;
  logic [5:0]        harm_out_q;
  logic              last_q, dropped_q;

  logic              in_acc;
  logic [4:0]        nmag;
  logic              nneg;
  logic              last_bin;
  logic              div_start, div_busy;
  logic [DivW-1:0]   div_dvd, div_quot;
  logic [CntW-1:0]   div_rem;
  logic signed [AccW-1:0] sre, sim;
  logic              core_busy;
  logic [AccW-1:0]   mag;
  logic              mag_neg;
  logic [AccW:0]     mag_rnd;
  core_ctrl_t        ctrl;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign nmag     = 5'((bin_q + 6'd1) >> 1);
  assign nneg     = bin_q[0];
  assign last_bin = bin_q == {harm_q, 1'b0};

  // magnitude of the sum being scaled and the sign of the coefficient
  always_comb begin
    if (op_q == OP_RE) begin
      mag_neg = sim[AccW-1];
      mag     = mag_neg ? AccW'(-sim) : AccW'(sim);
    end else begin
      mag_neg = !sre[AccW-1] && (sre != '0);
      mag     = sre[AccW-1] ? AccW'(-sre) : AccW'(sre);
    end
    mag_rnd = {1'b0, mag} + (AccW+1)'({count_q, 10'd0});
  end

  // divider operand per operation
  always_comb begin
    case (op_q)
      OP_MOD:  div_dvd = DivW'(nmag);
      OP_PH:   div_dvd = DivW'({nmod_q, 10'd0});
      default: div_dvd = mag_rnd[DivW+10:11];
    endcase
  end

  assign div_start = state_q == S_DGO;

  function automatic logic [CoefW-1:0] sat(logic neg, logic [DivW-1:0] q);
    logic [CoefW-1:0] r;
    if (neg) r = (q > DivW'(65536)) ? CoefW'(-65536) : CoefW'(-q);
    else     r = (q > DivW'(65535)) ? CoefW'(65535) : q[CoefW-1:0];
    return r;
  endfunction

  // sequencer: per bin, mod, phase step, accumulate, scale re, scale im, emit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_MOD;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      bin_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (count_q < CntW'(MaxPoints)) count_q <= count_q + 1'b1;
            else ovf_q <= 1'b1;
            if (last_point_i) begin
              bin_q   <= '0;
              op_q    <= OP_MOD;
              state_q <= S_DGO;
            end
          end
        end
        S_DGO:   state_q <= S_DWAIT;
        S_DWAIT: begin
          if (!div_busy) begin
            unique case (op_q)
              OP_MOD: begin
                nmod_q  <= (nneg && div_rem != '0) ? count_q - div_rem
                         : (nneg ? '0 : div_rem);
                op_q    <= OP_PH;
                state_q <= S_DGO;
              end
              OP_PH: begin
                step_q_q <= div_quot[TabW-1:0];
                step_r_q <= {div_rem, 1'b0};
                state_q  <= S_AGO;
              end
              OP_RE: begin
                coef_re_q <= sat(mag_neg, div_quot);
                op_q      <= OP_IM;
                state_q   <= S_DGO;
              end
              default: begin
                coef_im_q   <= sat(mag_neg, div_quot);
                harm_out_q  <= nneg ? 6'(-{1'b0, nmag}) : {1'b0, nmag};
                last_q      <= last_bin;
                dropped_q   <= ovf_q;
                out_valid_q <= 1'b1;
                state_q     <= S_EMIT;
              end
            endcase
          end
        end
        S_AGO:   state_q <= S_AWAIT;
        S_AWAIT: begin
          if (!core_busy) begin
            op_q    <= OP_RE;
            state_q <= S_DGO;
          end
        end
        S_EMIT: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            if (last_bin) begin
              count_q <= '0;
              ovf_q   <= 1'b0;
              state_q <= S_IDLE;
            end else begin
              bin_q   <= bin_q + 1'b1;
              op_q    <= OP_MOD;
              state_q <= S_DGO;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign ctrl = '{start:  state_q == S_AGO,
                  n_pts:  count_q,
                  nmod:   nmod_q,
                  step_q: step_q_q,
                  step_r: step_r_q,
                  cx:     cx_q,
                  cy:     cy_q};

  dsb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (count_q),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  dsb_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (in_acc && (count_q < CntW'(MaxPoints))),
    .wr_addr_i (count_q[AddrW-1:0]),
    .wr_data_i ({point_y_i, point_x_i}),
    .ctrl_i    (ctrl),
    .busy_o    (core_busy),
    .sre_o     (sre),
    .sim_o     (sim)
  );

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign coef_re_o   = coef_re_q;
  assign coef_im_o   = coef_im_q;
  assign harmonic_o  = harm_out_q;
  assign last_o      = last_q;
  assign dropped_o   = dropped_q;

endmodule

// ----- hdl/dsb_checker.sv -----
// ----------------------------------------------------------------------------
// dsb_checker
// Port-level checks on the selected-bin transform, bound to the top level.
// ----------------------------------------------------------------------------
module dsb_checker
  import dsb_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic [CoordW-1:0] point_x_i,
  input logic [CoordW-1:0] point_y_i,
  input logic              last_point_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [CoefW-1:0]  coef_re_o,
  input logic [CoefW-1:0]  coef_im_o,
  input logic [5:0]        harmonic_o,
  input logic              last_o,
  input logic              dropped_o,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [3:0]        paddr,
  input logic [31:0]       pwdata,
  input logic [31:0]       prdata,
  input logic              pready
);

  // a stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(coef_re_o)
      && $stable(coef_im_o) && $stable(harmonic_o) && $stable(last_o))
    else $error("stalled output word changed");

  // no point is taken while bins are being emitted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open during emission");

  // a last point starts the transform
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_point_i |=> in_stall_o)
    else $error("last point did not start transform");

  // the input reopens after the final bin is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_o |=> !in_stall_o && !out_valid_o)
    else $error("block did not return to idle after final bin");

endmodule

bind dft_selected_bins dsb_checker u_dsb_checker (.*);

// ----- tb/tb_dft_selected_bins.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dft_selected_bins
// Self-checking bench for the selected-bin transform. Bursts of traced points
// go in over the valid/stall port, and each bin word that comes out is
// checked against a bench-side bit-exact model of the accumulate, the
// twiddle table and the output scaling. The run covers register extremes,
// random stalls on both ports and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_dft_selected_bins;
  import dsb_pkg::*;

  localparam int WatchLimit = 20000;
  localparam int PipeDrain  = 200;

  // register byte addresses
  typedef enum logic [3:0] {
    RegHarm  = 4'd0,
    RegCtrX  = 4'd4,
    RegCtrY  = 4'd8,
    RegSpare = 4'd12
  } reg_addr_e;

  typedef struct {
    logic signed [CoefW-1:0] re;
    logic signed [CoefW-1:0] im;
    logic signed [5:0]       harm;
    logic                    last;
    logic                    drop;
  } bin_word_t;

  typedef struct {
    int unsigned x;
    int unsigned y;
    bit          last;
  } point_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CoordW-1:0] pt_x = '0;
  logic [CoordW-1:0] pt_y = '0;
  logic              pt_last = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b1;
  logic signed [CoefW-1:0] coef_re, coef_im;
  logic signed [5:0] harmonic;
  logic              last, dropped;
  logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  always #4 clk_i = ~clk_i;

  dft_selected_bins i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .point_x_i    (pt_x),
    .point_y_i    (pt_y),
    .last_point_i (pt_last),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .coef_re_o    (coef_re),
    .coef_im_o    (coef_im),
    .harmonic_o   (harmonic),
    .last_o       (last),
    .dropped_o    (dropped),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // bench copy of state and registers
  int unsigned pts_x [MaxPoints];
  int unsigned pts_y [MaxPoints];
  int unsigned pts_cnt = 0;
  bit          pts_ovf = 1'b0;
  int unsigned harm_k = 2;
  int unsigned ctr_x = 960;
  int unsigned ctr_y = 540;
  int          cos_q15 [TableSize];
  int          sin_q15 [TableSize];
  bin_word_t   bins_due [$];
  int          errors = 0;
  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;
  bit          hold_long = 1'b0;
  bit          long_done = 1'b0;
  int          n_items = 0;

  // taylor series in q30, stage clamped to [0, 1]
  function automatic longint series_q30(longint x2, bit want_sin);
    longint t, p;
    int     den;
    t = OneQ30;
    for (int i = 0; i < 6; i++) begin
      den = want_sin ? (156 - (i == 0 ? 0 : 0)) : 0;
      case (i)
        0: den = want_sin ? 156 : 132;
        1: den = want_sin ? 110 : 90;
        2: den = want_sin ? 72 : 56;
        3: den = want_sin ? 42 : 30;
        4: den = want_sin ? 20 : 12;
        default: den = want_sin ? 6 : 2;
      endcase
      p = ((x2 * t) >>> 30) / den;
      t = OneQ30 - p;
      if (t < 0) t = 0;
      if (t > OneQ30) t = OneQ30;
    end
    return t;
  endfunction

  function automatic int round_q15(longint v);
    longint r;
    if (v < 0) v = 0;
    if (v > OneQ30) v = OneQ30;
    r = (v + 16384) >>> 15;
    return (r > 32767) ? 32767 : int'(r);
  endfunction

  // output scaling: round half away from zero, then saturate
  function automatic logic signed [CoefW-1:0] scale_coef(longint s, longint div);
    longint mag, r;
    mag = (s < 0) ? -s : s;
    r = (mag + div / 2) / div;
    if (s < 0) return (r > 65536) ? CoefW'(-65536) : CoefW'(-r);
    return (r > 65535) ? 17'sd65535 : CoefW'(r);
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  // store the point; on a last point queue every bin of the burst
  task automatic predict_point(int unsigned x, int unsigned y, bit lst);
    longint    sre, sim, dx, dy, nn, nmod, ph, k, div;
    int        n;
    int        nbins;
    bin_word_t w;
    if (pts_cnt < MaxPoints) begin
      pts_x[pts_cnt] = x;
      pts_y[pts_cnt] = y;
      pts_cnt++;
    end else begin
      pts_ovf = 1'b1;
    end
    if (!lst) return;
    nbins = 2 * harm_k + 1;
    nn = pts_cnt;
    div = nn << 11;
    for (int b = 0; b < nbins; b++) begin
      n = (b == 0) ? 0 : ((b % 2) ? -((b + 1) / 2) : b / 2);
      nmod = (n >= 0) ? n % nn : (nn - ((-n) % nn)) % nn;
      sre = 0;
      sim = 0;
      for (int i = 0; i < nn; i++) begin
        dx = longint'(pts_x[i]) - ctr_x;
        dy = longint'(pts_y[i]) - ctr_y;
        ph = (nmod * i) % nn;
        k = (ph * TableSize * 2 + nn) / (2 * nn);
        if (k >= TableSize) k = 0;
        sre += dx * cos_q15[k] + dy * sin_q15[k];
        sim += dy * cos_q15[k] - dx * sin_q15[k];
      end
      w.re = scale_coef(sim, div);
      w.im = scale_coef(-sre, div);
      w.harm = 6'(n);
      w.last = (b + 1 == nbins);
      w.drop = pts_ovf;
      bins_due.insert(bins_due.size(), w);
    end
    pts_cnt = 0;
    pts_ovf = 1'b0;
  endtask

  // one point word, with a random gap ahead of it
  task automatic send_point(int unsigned x, int unsigned y, bit lst);
    int gap;
    gap = tx_idle ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    pt_x <= CoordW'(x);
    pt_y <= CoordW'(y);
    pt_last <= lst;
    do @(posedge clk_i); while (in_stall);
    predict_point(x, y, lst);
    n_items++;
    @(negedge clk_i);
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    wait (bins_due.size() == 0);
    repeat (PipeDrain) @(negedge clk_i);
  endtask

  task automatic reg_write(reg_addr_e a, int unsigned v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (a)
      RegHarm: harm_k = v & 32'h1f;
      RegCtrX: ctr_x = v & 32'hfff;
      RegCtrY: ctr_y = v & 32'hfff;
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic random_burst(int len);
    for (int i = 0; i < len; i++)
      send_point($urandom_range(0, 4095), $urandom_range(0, 4095), i == len - 1);
  endtask

  // directed points: extremes, single-point bursts, center-equal points
  point_row_t dir_rows [] = '{
    '{960, 540, 1},
    '{0, 0, 0}, '{4095, 4095, 0}, '{4095, 0, 0}, '{0, 4095, 1},
    '{4095, 4095, 1},
    '{0, 0, 1},
    '{100, 200, 0}, '{300, 400, 1},
    '{1, 2, 0}, '{4094, 4093, 0}, '{2048, 2048, 0}, '{2047, 1, 0},
    '{960, 540, 0}, '{4095, 0, 0}, '{0, 4095, 1},
    '{2730, 1365, 0}, '{1365, 2730, 0}, '{0, 0, 1}
  };

  // output side: random hold-off per word, plus one long hold
  initial begin
    int w;
    forever begin
      if (hold_long) begin
        w = 400;
        hold_long = 1'b0;
      end else begin
        w = rx_idle ? $urandom_range(0, 13) : 0;
      end
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(negedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid);
      @(negedge clk_i);
    end
  end

  // check each accepted bin word against the oldest expectation
  always @(posedge clk_i) begin
    bin_word_t e;
    if (rst_ni && out_valid && !out_stall) begin
      if (bins_due.size() == 0) begin
        $display("unexpected bin word, harmonic %0d", harmonic);
        errors++;
      end else begin
        e = bins_due.pop_front();
        if (coef_re !== e.re) report("coef_re", coef_re, e.re);
        if (coef_im !== e.im) report("coef_im", coef_im, e.im);
        if (harmonic !== e.harm) report("harmonic", harmonic, e.harm);
        if (last !== e.last) report("last", last, e.last);
        if (dropped !== e.drop) report("dropped", dropped, e.drop);
      end
    end
  end

  // watchdog on cycles with no word moving
  int quiet = 0;
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WatchLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    longint x, x2;
    int     c15, s15;
    int     quad, rm;
    // twiddle table in q1.15
    for (int k = 0; k < TableSize; k++) begin
      quad = (k * 4) / TableSize;
      rm = (k * 4) % TableSize;
      x = (longint'(rm) * HalfPiQ30) / TableSize;
      x2 = (x * x) >>> 30;
      s15 = round_q15((x * series_q30(x2, 1'b1)) >>> 30);
      c15 = round_q15(series_q30(x2, 1'b0));
      case (quad)
        0: begin cos_q15[k] = c15; sin_q15[k] = s15; end
        1: begin cos_q15[k] = -s15; sin_q15[k] = c15; end
        2: begin cos_q15[k] = -c15; sin_q15[k] = -s15; end
        default: begin cos_q15[k] = s15; sin_q15[k] = -c15; end
      endcase
    end

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part at reset settings
    foreach (dir_rows[i]) send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].last);
    idle_input();

    // register extremes, including an unmapped address
    reg_write(RegHarm, 31);
    reg_write(RegCtrX, 0);
    reg_write(RegCtrY, 4095);
    reg_write(RegSpare, 32'hffff_ffff);
    send_point(4095, 0, 0);
    send_point(0, 4095, 0);
    send_point(2048, 2048, 1);
    idle_input();
    reg_write(RegHarm, 0);
    reg_write(RegCtrX, 4095);
    reg_write(RegCtrY, 0);
    send_point(0, 4095, 0);
    send_point(4095, 0, 1);
    idle_input();

    // random phases with new settings between them
    while (n_items < 230) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      reg_write(RegHarm, ($urandom_range(0, 4) == 0) ? 31 : $urandom_range(0, 8));
      reg_write(RegCtrX, $urandom_range(0, 4095));
      reg_write(RegCtrY, $urandom_range(0, 4095));
      if (n_items > 100 && !long_done) begin
        hold_long = 1'b1;
        long_done = 1'b1;
      end
      repeat ($urandom_range(2, 5))
        random_burst(($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(1, 10));
      idle_input();
    end

    // closing burst with no gaps
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    reg_write(RegHarm, 1);
    random_burst(3);
    in_valid <= 1'b0;
    wait (bins_due.size() == 0);
    repeat (PipeDrain) @(negedge clk_i);

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
